// ===== design/csce_pkg.sv =====
// Shared types, constants and the microcode program of the Clenshaw evaluator.
// Used by csce_seq, csce_dp and chebyshev_series_clenshaw_eval. No dependencies.
package csce_pkg;

  localparam int MaxTerms  = 64;
  localparam int IdxW      = $clog2(MaxTerms);
  localparam int CoefW     = 32;
  localparam int XW        = 32;
  localparam int BW        = 48;
  localparam int SplitBits = 29;
  localparam int PcW       = 3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  typedef enum logic [2:0] {
    J_NEVER,
    J_ALWAYS,
    J_NOSTART,
    J_KNZ,
    J_OUTBUSY
  } jcond_t;

  typedef enum logic [PcW-1:0] {
    PC_IDLE = 3'd0,
    PC_MLO  = 3'd1,
    PC_MHI  = 3'd2,
    PC_ACC  = 3'd3,
    PC_FIN  = 3'd4,
    PC_RET  = 3'd5
  } pc_t;

  typedef struct packed {
    logic   idle;
    logic   ld_p;
    logic   ld_qs;
    logic   ld_b;
    logic   ld_out;
    jcond_t jc;
    pc_t    jaddr;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic k_nz;
    logic out_busy;
  } status_t;

  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t w;
    w = '{idle: 1'b0, ld_p: 1'b0, ld_qs: 1'b0, ld_b: 1'b0, ld_out: 1'b0,
          jc: J_ALWAYS, jaddr: PC_IDLE};
    case (pc)
      PC_IDLE: begin
        w.idle  = 1'b1;
        w.jc    = J_NOSTART;
        w.jaddr = PC_IDLE;
      end
      PC_MLO: begin
        w.ld_p = 1'b1;
        w.jc   = J_NEVER;
      end
      PC_MHI: begin
        w.ld_qs = 1'b1;
        w.jc    = J_NEVER;
      end
      PC_ACC: begin
        w.ld_b  = 1'b1;
        w.jc    = J_KNZ;
        w.jaddr = PC_MLO;
      end
      PC_FIN: begin
        w.ld_out = 1'b1;
        w.jc     = J_OUTBUSY;
        w.jaddr  = PC_FIN;
      end
      PC_RET: begin
        w.jc    = J_ALWAYS;
        w.jaddr = PC_IDLE;
      end
      default: begin
        w.jc    = J_ALWAYS;
        w.jaddr = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== design/chebyshev_series_clenshaw_eval.sv =====
// Chebyshev series evaluator, Clenshaw backward recurrence in fixed point.
// Input request: opcode, coef_index, coef_value, x_value on in_valid/in_stall.
//   A write request (opcode 0) stores coef_value in slot coef_index; no result.
//   An evaluate request (opcode 1) returns one result on out_valid/out_stall:
//   series_value (Q8.24, saturated) and saturated.
// Config: series_order written on cfg_valid/cfg_ready; change it only when idle.
// Timing: a write request completes on accept. An evaluate request runs the
//   three-step microcode loop (multiply low half, multiply high half, accumulate),
//   which shares one 32x30 multiplier and reads one coefficient per pass, then
//   loads the result into the output register; the next request is taken once
//   the sequencer is back in idle.
//   One request is in flight at a time; in_stall is high while it runs.
// Reset: clears the sequencer, the output valid and series_order; the
//   coefficient table is not cleared and must be written before use.
// Stall: a pending result holds in the output register; the sequencer waits in
//   its FIN step until the register can be loaded.
// Depends on csce_pkg, csce_seq, csce_dp, csce_ram.
module chebyshev_series_clenshaw_eval (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              opcode,
  input  logic [csce_pkg::IdxW-1:0]         coef_index,
  input  logic signed [csce_pkg::CoefW-1:0] coef_value,
  input  logic signed [csce_pkg::XW-1:0]    x_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [csce_pkg::CoefW-1:0] series_value,
  output logic                              saturated,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [csce_pkg::IdxW-1:0]         series_order
);

  csce_pkg::ctrl_t   ctrl;
  csce_pkg::status_t stat;
  logic [csce_pkg::IdxW-1:0] order;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      order <= '0;
    end else if (cfg_valid && cfg_ready) begin
      order <= series_order;
    end
  end

  csce_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  csce_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .coef_index   (coef_index),
    .coef_value   (coef_value),
    .x_value      (x_value),
    .order        (order),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .series_value (series_value),
    .saturated    (saturated)
  );

endmodule

// ===== design/csce_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module csce_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/csce_seq.sv =====
// Microcode sequencer: step counter, control store lookup, conditional jumps.
// Depends on csce_pkg.
module csce_seq (
  input  logic             clk,
  input  logic             rst,
  input  csce_pkg::status_t stat,
  output csce_pkg::ctrl_t   ctrl
);

  csce_pkg::pc_t pc, pc_next;
  logic          take;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= csce_pkg::PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    ctrl = csce_pkg::ucode(pc);
    case (ctrl.jc)
      csce_pkg::J_NEVER:   take = 1'b0;
      csce_pkg::J_ALWAYS:  take = 1'b1;
      csce_pkg::J_NOSTART: take = !stat.start;
      csce_pkg::J_KNZ:     take = stat.k_nz;
      csce_pkg::J_OUTBUSY: take = stat.out_busy;
      default:             take = 1'b1;
    endcase
    pc_next = take ? ctrl.jaddr : csce_pkg::pc_t'(pc + 1'b1);
  end

endmodule

// ===== design/csce_dp.sv =====
// Datapath: shared 32x30 multiplier, recurrence registers, saturation, output register.
// Depends on csce_pkg and csce_ram.
module csce_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  csce_pkg::ctrl_t             ctrl,
  output csce_pkg::status_t           stat,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        opcode,
  input  logic [csce_pkg::IdxW-1:0]   coef_index,
  input  logic signed [csce_pkg::CoefW-1:0] coef_value,
  input  logic signed [csce_pkg::XW-1:0]    x_value,
  input  logic [csce_pkg::IdxW-1:0]   order,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [csce_pkg::CoefW-1:0] series_value,
  output logic                        saturated
);

  localparam int MW = csce_pkg::XW + 30;
  localparam int QW = csce_pkg::XW + csce_pkg::BW - csce_pkg::SplitBits;
  localparam int TW = MW - csce_pkg::SplitBits;
  localparam int SW = csce_pkg::BW + 2;
  localparam int NW = QW + 1;
  localparam int DW = csce_pkg::BW + 2;

  logic accept, start, wr, out_free;
  logic signed [csce_pkg::XW-1:0]   x;
  logic [csce_pkg::IdxW-1:0]        k;
  logic signed [csce_pkg::BW-1:0]   b0, b1, b2;
  logic signed [MW-1:0]             p;
  logic signed [QW-1:0]             q;
  logic signed [SW-1:0]             s;
  logic                             flag;
  logic signed [csce_pkg::CoefW-1:0] c;
  logic signed [29:0]               mop;
  logic signed [MW-1:0]             prod;
  logic signed [MW-1:0]             pr;
  logic signed [TW-1:0]             t;
  logic signed [NW-1:0]             nv;
  logic signed [csce_pkg::BW-1:0]   bsat;
  logic                             bclip;
  logic signed [DW-1:0]             d;
  logic signed [DW-2:0]             half;
  logic signed [csce_pkg::CoefW-1:0] hsat;
  logic                             hclip;

  assign in_stall = !ctrl.idle;
  assign accept   = in_valid && ctrl.idle;
  assign start    = accept && (opcode == csce_pkg::OP_EVAL);
  assign wr       = accept && (opcode == csce_pkg::OP_WRITE);
  assign out_free = !out_valid || !out_stall;

  assign stat.start    = start;
  assign stat.k_nz     = (k != '0);
  assign stat.out_busy = !out_free;

  csce_ram #(.Width(csce_pkg::CoefW), .Depth(csce_pkg::MaxTerms)) u_ram (
    .clk   (clk),
    .we    (wr),
    .waddr (coef_index),
    .wdata (coef_value),
    .raddr (k),
    .rdata (c)
  );

  // low part of b is unsigned, high part signed
  always_comb begin
    if (ctrl.ld_p) begin
      mop = $signed({1'b0, b0[csce_pkg::SplitBits-1:0]});
    end else begin
      mop = 30'($signed(b0[csce_pkg::BW-1:csce_pkg::SplitBits]));
    end
    prod = MW'(x * mop);
    pr   = p + MW'(64'sd1 <<< (csce_pkg::SplitBits - 1));
    t    = pr[MW-1:csce_pkg::SplitBits];
    nv   = NW'(q) + NW'(s);
    bclip = (nv[NW-1:csce_pkg::BW-1] != '0) && (nv[NW-1:csce_pkg::BW-1] != '1);
    if (bclip) begin
      bsat = nv[NW-1] ? {1'b1, {(csce_pkg::BW-1){1'b0}}} : {1'b0, {(csce_pkg::BW-1){1'b1}}};
    end else begin
      bsat = nv[csce_pkg::BW-1:0];
    end
    d     = DW'(b0) - DW'(b2) + DW'(1);
    half  = d[DW-1:1];
    hclip = (half[DW-2:csce_pkg::CoefW-1] != '0) && (half[DW-2:csce_pkg::CoefW-1] != '1);
    if (hclip) begin
      hsat = half[DW-2] ? {1'b1, {(csce_pkg::CoefW-1){1'b0}}}
                        : {1'b0, {(csce_pkg::CoefW-1){1'b1}}};
    end else begin
      hsat = half[csce_pkg::CoefW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= x_value;
      k    <= order;
      b0   <= '0;
      b1   <= '0;
      b2   <= '0;
      flag <= 1'b0;
    end
    if (ctrl.ld_p) begin
      p <= prod;
    end
    if (ctrl.ld_qs) begin
      q <= prod[QW-1:0];
      s <= SW'(c) + SW'(t) - SW'(b1);
    end
    if (ctrl.ld_b) begin
      b2   <= b1;
      b1   <= b0;
      b0   <= bsat;
      flag <= flag | bclip;
      if (k != '0) begin
        k <= k - 1'b1;
      end
    end
    if (ctrl.ld_out && out_free) begin
      series_value <= hsat;
      saturated    <= flag | hclip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.ld_out && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== bench/chebyshev_series_clenshaw_eval_tb.sv =====
// Self-checking bench for chebyshev_series_clenshaw_eval: write and evaluate requests
// against a bit-exact Clenshaw predictor, with random idling on both channels.
// Depends on csce_pkg and the chebyshev_series_clenshaw_eval RTL.
module chebyshev_series_clenshaw_eval_tb;

  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 12;
  localparam logic signed [95:0] B_HI     = (96'sd1 <<< 47) - 96'sd1;
  localparam logic signed [95:0] B_LO     = -(96'sd1 <<< 47);
  localparam logic signed [95:0] Q_HI     = 96'sd2147483647;
  localparam logic signed [95:0] Q_LO     = -96'sd2147483648;
  localparam logic signed [95:0] HALF_LSB = 96'sd268435456;

  typedef struct packed {
    logic signed [csce_pkg::CoefW-1:0] value;
    logic                              clipped;
  } series_result_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic opcode;
  logic [csce_pkg::IdxW-1:0] coef_index;
  logic signed [csce_pkg::CoefW-1:0] coef_value;
  logic signed [csce_pkg::XW-1:0] x_value;
  logic out_valid;
  logic out_stall;
  logic signed [csce_pkg::CoefW-1:0] series_value;
  logic saturated;
  logic cfg_valid;
  logic cfg_ready;
  logic [csce_pkg::IdxW-1:0] series_order;

  logic signed [csce_pkg::CoefW-1:0] coef_mem [csce_pkg::MaxTerms];
  bit written [csce_pkg::MaxTerms];
  int unsigned order_cfg;
  series_result_t pending_sums[$];
  int mismatch_count;
  bit tx_gaps_on;
  bit rx_gaps_on;
  int hold_go;
  int hold_done;
  int rx_wait;

  chebyshev_series_clenshaw_eval u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .coef_index(coef_index),
    .coef_value(coef_value), .x_value(x_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .series_value(series_value), .saturated(saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .series_order(series_order)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #16000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic series_result_t clenshaw_sum(
      input logic signed [csce_pkg::XW-1:0] x);
    logic signed [95:0] b0, b1, b2, prod, half;
    logic hit;
    int k;
    series_result_t r;
    b0 = '0;
    b1 = '0;
    b2 = '0;
    hit = 1'b0;
    for (k = int'(order_cfg); k >= 0; k--) begin
      b2 = b1;
      b1 = b0;
      prod = (96'(x) * b1 + HALF_LSB) >>> csce_pkg::SplitBits;
      b0 = 96'(coef_mem[k]) + prod - b2;
      if (b0 > B_HI) begin
        b0 = B_HI;
        hit = 1'b1;
      end else if (b0 < B_LO) begin
        b0 = B_LO;
        hit = 1'b1;
      end
    end
    half = (b0 - b2 + 96'sd1) >>> 1;
    if (half > Q_HI) begin
      half = Q_HI;
      hit = 1'b1;
    end else if (half < Q_LO) begin
      half = Q_LO;
      hit = 1'b1;
    end
    r.value = half[csce_pkg::CoefW-1:0];
    r.clipped = hit;
    return r;
  endfunction

  // one request; returns at the edge that accepted it
  task automatic push_request(input logic op, input logic [csce_pkg::IdxW-1:0] idx,
                              input logic signed [csce_pkg::CoefW-1:0] cv,
                              input logic signed [csce_pkg::XW-1:0] xv);
    int gap;
    if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    coef_index <= idx;
    coef_value <= cv;
    x_value <= xv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == csce_pkg::OP_WRITE) begin
      coef_mem[idx] = cv;
      written[idx] = 1'b1;
    end else begin
      pending_sums.push_back(clenshaw_sum(xv));
    end
  endtask

  task automatic write_coef(input int idx, input logic signed [csce_pkg::CoefW-1:0] cv);
    push_request(csce_pkg::OP_WRITE, csce_pkg::IdxW'(idx), cv, csce_pkg::XW'($urandom));
  endtask

  task automatic eval_at(input logic signed [csce_pkg::XW-1:0] xv);
    push_request(csce_pkg::OP_EVAL, csce_pkg::IdxW'($urandom),
                 csce_pkg::CoefW'($urandom), xv);
  endtask

  function automatic logic signed [csce_pkg::CoefW-1:0] rand_coef();
    case ($urandom_range(0, 3))
      0: return csce_pkg::CoefW'($urandom);
      1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return csce_pkg::CoefW'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endcase
  endfunction

  function automatic logic signed [csce_pkg::XW-1:0] rand_x();
    if ($urandom_range(0, 5) == 0)
      return csce_pkg::XW'($urandom);
    return csce_pkg::XW'($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // idle only; fills any slot the new order will read
  task automatic set_order(input int unsigned ord);
    int i;
    drain();
    cfg_valid <= 1'b1;
    series_order <= csce_pkg::IdxW'(ord);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    order_cfg = ord;
    for (i = 0; i <= int'(ord); i++)
      if (!written[i]) write_coef(i, rand_coef());
  endtask

  task automatic test_directed_extremes();
    set_order(1);
    write_coef(0, 32'sh7FFFFFFF);
    write_coef(1, 32'sh7FFFFFFF);
    eval_at(32'sh4000_0000);
    eval_at(-32'sh4000_0000);
    write_coef(0, 32'sh80000000);
    write_coef(1, 32'sh80000000);
    eval_at(32'sh4000_0000);
    eval_at(32'sh0000_0000);
    eval_at(32'sh8000_0000);
    eval_at(32'sh7FFF_FFFF);
    write_coef(0, 32'sh0100_0000);
    write_coef(1, -32'sh0080_0000);
    eval_at(32'sh5555_5555);
    eval_at(32'sh2000_0000);
  endtask

  task automatic test_deep_saturation();
    set_order(csce_pkg::MaxTerms - 1);
    write_coef(csce_pkg::MaxTerms - 1, 32'sh7FFFFFFF);
    write_coef(0, 32'sh80000000);
    eval_at(32'sh7FFF_FFFF);
    eval_at(32'sh8000_0000);
    eval_at(32'sh4000_0000);
    write_coef(csce_pkg::MaxTerms - 1, 32'sh0000_0000);
    eval_at(32'sh0000_0000);
    eval_at(-32'sh2000_0000);
  endtask

  task automatic run_mix(input int unsigned ord, input int count);
    int n;
    set_order(ord);
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 3) == 0)
        write_coef($urandom_range(0, csce_pkg::MaxTerms - 1), rand_coef());
      else
        eval_at(rand_x());
    end
  endtask

  task automatic test_random_orders();
    int unsigned orders [9] = '{0, 3, 1, 7, 63, 12, 2, 31, 5};
    int counts [9] = '{125, 125, 90, 125, 45, 125, 90, 45, 100};
    int p;
    for (p = 0; p < 9; p++) begin
      tx_gaps_on = (p % 3) != 2;
      rx_gaps_on = (p % 3) != 1;
      run_mix(orders[p], counts[p]);
    end
  endtask

  // receiver holds off while requests keep coming
  task automatic test_output_backpressure();
    int n;
    set_order(2);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    hold_go++;
    for (n = 0; n < 12; n++) eval_at(rand_x());
  endtask

  task automatic test_steady_stream();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    run_mix(9, 80);
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_done != hold_go) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_done = hold_go;
      end else if (rx_wait > 0) begin
        out_stall <= 1'b1;
        rx_wait--;
      end else if (rx_gaps_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        rx_wait = $urandom_range(0, 7);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    series_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: result with none pending: expected none, got value %0d saturated %0b",
                 $time, series_value, saturated);
        mismatch_count++;
      end else begin
        want = pending_sums.pop_front();
        if (series_value !== want.value) begin
          $display("%0t: series_value expected %0d got %0d", $time, want.value,
                   series_value);
          mismatch_count++;
        end
        if (saturated !== want.clipped) begin
          $display("%0t: saturated expected %0b got %0b", $time, want.clipped, saturated);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    opcode <= csce_pkg::OP_WRITE;
    coef_index <= '0;
    coef_value <= '0;
    x_value <= '0;
    cfg_valid <= 1'b0;
    series_order <= '0;
    order_cfg = 0;
    mismatch_count = 0;
    hold_go = 0;
    hold_done = 0;
    rx_wait = 0;
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    foreach (written[i]) begin
      written[i] = 1'b0;
      coef_mem[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    test_deep_saturation();
    test_random_orders();
    test_output_backpressure();
    test_steady_stream();
    drain();
    if (mismatch_count == 0 && pending_sums.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/csce_pkg.sv
design/csce_ram.sv
design/csce_seq.sv
design/csce_dp.sv
design/chebyshev_series_clenshaw_eval.sv
bench/chebyshev_series_clenshaw_eval_tb.sv
